// ----- design/spi_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// spi_pkg: shared constants and types for the sphere/polygon intersection core
// Widths of the fixed-point datapath, corner storage depth and sequencer codes.
// ----------------------------------------------------------------------------
package spi_pkg;

    localparam int MAX_CORNERS = 16;
    localparam int IW          = $clog2(MAX_CORNERS);
    localparam int CW          = $clog2(MAX_CORNERS + 1);

    localparam int CRD_W = 32;
    localparam int RAD_W = 31;
    localparam int PW    = 36;
    localparam int BW    = 36;
    localparam int MW    = 72;
    localparam int AW    = 112;
    localparam int DDW   = 40;
    localparam int NR2_W = 64;
    localparam int T_W   = 32;
    localparam int BCW   = $clog2(BW);
    localparam int KW    = 4;

    typedef enum logic [12:0] {
        ST_IDLE   = 13'b0000000000001,
        ST_DIST   = 13'b0000000000010,
        ST_PROJ   = 13'b0000000000100,
        ST_RAD    = 13'b0000000001000,
        ST_INSIDE = 13'b0000000010000,
        ST_EDGE   = 13'b0000000100000,
        ST_CLOSE  = 13'b0000001000000,
        ST_MUL    = 13'b0000010000000,
        ST_DIV    = 13'b0000100000000,
        ST_RDA    = 13'b0001000000000,
        ST_RDB    = 13'b0010000000000,
        ST_RDC    = 13'b0100000000000,
        ST_OUT    = 13'b1000000000000
    } t_state;

endpackage

`default_nettype wire

// ----- design/sphere_polygon_intersect_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sphere_polygon_intersect_core: sphere versus convex planar polygon test
// Stores one face's corners, then runs plane distance, projection, inside
// test and edge closest-point tests on one shared shift-add multiply/divide unit.
// ----------------------------------------------------------------------------
// A vertex beat is taken when start is high and busy is low; a beat without
// final_vertex stores its corner, if fewer than MAX_CORNERS are held, and
// leaves busy low. The final beat starts the face evaluation, during which
// busy stays high, and ends with a single o_valid cycle carrying o_touches;
// the receiver cannot stall it. Multiplies and divisions run on one shift-add
// unit (36 multiplier bits); evaluation ends early when the plane distance
// rejects or a test hits early.
module sphere_polygon_intersect_core (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic signed [spi_pkg::CRD_W-1:0]  i_vert_x,
    input  wire logic signed [spi_pkg::CRD_W-1:0]  i_vert_y,
    input  wire logic signed [spi_pkg::CRD_W-1:0]  i_vert_z,
    input  wire logic signed [spi_pkg::CRD_W-1:0]  i_ball_x,
    input  wire logic signed [spi_pkg::CRD_W-1:0]  i_ball_y,
    input  wire logic signed [spi_pkg::CRD_W-1:0]  i_ball_z,
    input  wire logic        [spi_pkg::RAD_W-1:0]  i_ball_radius,
    input  wire logic signed [spi_pkg::CRD_W-1:0]  i_norm_x,
    input  wire logic signed [spi_pkg::CRD_W-1:0]  i_norm_y,
    input  wire logic signed [spi_pkg::CRD_W-1:0]  i_norm_z,
    input  wire logic                              i_final_vertex,
    output logic                                   o_valid,
    output logic                                   o_touches
);
    import spi_pkg::*;

    t_state r_st, n_st, r_ret, n_ret;
    logic [KW-1:0]  r_k, n_k;
    logic [IW-1:0]  r_i, n_i;
    logic [CW-1:0]  r_cnt, n_cnt;
    logic [BCW-1:0] r_bit, n_bit;

    logic signed [CRD_W-1:0] r_c [3];
    logic signed [CRD_W-1:0] n_c [3];
    logic signed [CRD_W-1:0] r_n [3];
    logic signed [CRD_W-1:0] n_n [3];
    logic [RAD_W-1:0]        r_r, n_r;
    logic signed [CRD_W-1:0] r_dd, n_dd;
    logic signed [PW-1:0]    r_p [3];
    logic signed [PW-1:0]    n_p [3];
    logic signed [NR2_W-1:0] r_nr2, n_nr2;
    logic signed [MW-1:0]    r_m [3];
    logic signed [MW-1:0]    n_m [3];
    logic signed [MW-1:0]    r_d, n_d;
    logic [T_W-1:0]          r_t, n_t;
    logic signed [CRD_W-1:0] r_va [3];
    logic signed [CRD_W-1:0] n_va [3];
    logic signed [CRD_W-1:0] r_vb [3];
    logic signed [CRD_W-1:0] n_vb [3];
    logic signed [BW-1:0]    r_q [3];
    logic signed [BW-1:0]    n_q [3];
    logic signed [AW-1:0]    r_acc, n_acc, r_ma, n_ma;
    logic signed [BW-1:0]    r_mb, n_mb;
    logic                    r_msub, n_msub;
    logic                    r_spos, n_spos, r_sneg, n_sneg;
    logic                    r_touch, n_touch;

    logic [3*CRD_W-1:0] r_corner [MAX_CORNERS];
    logic [3*CRD_W-1:0] r_rd;

    logic signed [BW-1:0]    w_av [3];
    logic signed [BW-1:0]    w_bv [3];
    logic signed [BW-1:0]    w_ab [3];
    logic signed [BW-1:0]    w_ac [3];
    logic signed [BW-1:0]    w_pb [3];
    logic signed [BW-1:0]    w_cv [3];
    logic signed [CRD_W-1:0] w_rdv [3];
    logic signed [DDW-1:0]   w_dd, w_rr;
    logic signed [PW-1:0]    w_pq;
    logic signed [BW-1:0]    w_tq, w_tb;
    logic signed [AW-1:0]    w_alu_x, w_alu_y, w_sum;
    logic                    w_alu_sub;
    logic                    w_acc_beat, w_we, w_last;
    logic [IW-1:0]           w_j, w_raddr;

    logic                    iss_go, iss_clr, iss_nr2, iss_sub;
    logic signed [AW-1:0]    iss_a;
    logic signed [BW-1:0]    iss_b;

    assign busy      = (r_st != ST_IDLE);
    assign o_valid   = (r_st == ST_OUT);
    assign o_touches = r_touch;

    assign w_acc_beat = start && !busy;
    assign w_we       = w_acc_beat && (r_cnt < CW'(MAX_CORNERS));
    assign w_last     = (CW'(r_i) == r_cnt - CW'(1));
    assign w_j        = w_last ? '0 : r_i + 1'b1;
    assign w_raddr    = (r_st == ST_RDA) ? ((r_ret == ST_EDGE) ? w_j : r_i)
                                         : ((r_ret == ST_EDGE) ? r_i : w_j);

    assign w_rdv[0] = r_rd[3*CRD_W-1:2*CRD_W];
    assign w_rdv[1] = r_rd[2*CRD_W-1:CRD_W];
    assign w_rdv[2] = r_rd[CRD_W-1:0];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_av[k] = BW'(r_va[k]) - BW'(r_p[k]);
            w_bv[k] = BW'(r_vb[k]) - BW'(r_p[k]);
            w_ab[k] = BW'(r_vb[k]) - BW'(r_va[k]);
            w_ac[k] = BW'(r_p[k]) - BW'(r_va[k]);
            w_pb[k] = BW'(r_p[k]) - BW'(r_vb[k]);
            w_cv[k] = BW'(r_c[k]) - BW'(r_va[k]);
        end
    end

    assign w_dd = r_acc[DDW+29:30];
    assign w_rr = DDW'($signed({1'b0, r_r}));
    assign w_pq = r_acc[PW+29:30];
    assign w_tq = r_acc[BW+31:32];
    assign w_tb = BW'($signed({1'b0, r_t}));

    // shared adder: shift-add multiply steps and restoring divide steps
    always_comb begin
        if (r_st == ST_DIV) begin
            w_alu_x   = r_acc <<< 1;
            w_alu_y   = r_ma;
            w_alu_sub = 1'b1;
        end else begin
            w_alu_x   = r_acc;
            w_alu_y   = r_mb[0] ? r_ma : '0;
            w_alu_sub = r_msub ^ (r_bit == BCW'(BW - 1));
        end
        w_sum = w_alu_x + (w_alu_sub ? ~w_alu_y : w_alu_y) + AW'(w_alu_sub);
    end

    always_comb begin
        n_st = r_st;  n_ret = r_ret;  n_k = r_k;  n_i = r_i;
        n_cnt = r_cnt;  n_bit = r_bit;
        n_c = r_c;  n_n = r_n;  n_r = r_r;  n_dd = r_dd;  n_p = r_p;
        n_nr2 = r_nr2;  n_m = r_m;  n_d = r_d;  n_t = r_t;
        n_va = r_va;  n_vb = r_vb;  n_q = r_q;
        n_acc = r_acc;  n_ma = r_ma;  n_mb = r_mb;  n_msub = r_msub;
        n_spos = r_spos;  n_sneg = r_sneg;  n_touch = r_touch;
        iss_go = 1'b0;  iss_clr = 1'b0;  iss_nr2 = 1'b0;  iss_sub = 1'b0;
        iss_a = '0;  iss_b = '0;

        case (r_st)
            ST_IDLE: begin
                if (w_acc_beat) begin
                    if (r_cnt == '0) begin
                        n_c[0] = i_ball_x;  n_c[1] = i_ball_y;  n_c[2] = i_ball_z;
                        n_r    = i_ball_radius;
                        n_n[0] = i_norm_x;  n_n[1] = i_norm_y;  n_n[2] = i_norm_z;
                    end
                    if (w_we) begin
                        n_cnt = r_cnt + 1'b1;
                    end
                    if (i_final_vertex) begin
                        n_st = ST_DIST;
                        n_k  = '0;
                        n_i  = '0;
                    end
                end
            end
            ST_DIST: begin
                case (r_k)
                    4'd0: begin
                        n_st = ST_RDA;  n_ret = ST_DIST;  n_k = 4'd1;
                    end
                    4'd1: begin
                        iss_go = 1'b1;  iss_clr = 1'b1;
                        iss_a = AW'(r_n[0]);  iss_b = w_cv[0];
                    end
                    4'd2: begin
                        iss_go = 1'b1;  iss_a = AW'(r_n[1]);  iss_b = w_cv[1];
                    end
                    4'd3: begin
                        iss_go = 1'b1;  iss_a = AW'(r_n[2]);  iss_b = w_cv[2];
                    end
                    default: begin
                        if (w_dd > w_rr || w_dd < -w_rr) begin
                            n_touch = 1'b0;
                            n_st    = ST_OUT;
                        end else begin
                            n_dd = w_dd[CRD_W-1:0];
                            n_st = ST_PROJ;
                            n_k  = '0;
                        end
                    end
                endcase
            end
            ST_PROJ: begin
                case (r_k)
                    4'd0: begin
                        iss_go = 1'b1;  iss_clr = 1'b1;
                        iss_a = AW'(r_n[0]);  iss_b = BW'(r_dd);
                    end
                    4'd1: begin
                        n_p[0] = PW'(r_c[0]) - w_pq;
                        iss_go = 1'b1;  iss_clr = 1'b1;
                        iss_a = AW'(r_n[1]);  iss_b = BW'(r_dd);
                    end
                    4'd2: begin
                        n_p[1] = PW'(r_c[1]) - w_pq;
                        iss_go = 1'b1;  iss_clr = 1'b1;
                        iss_a = AW'(r_n[2]);  iss_b = BW'(r_dd);
                    end
                    default: begin
                        n_p[2] = PW'(r_c[2]) - w_pq;
                        n_st   = ST_RAD;
                        n_k    = '0;
                    end
                endcase
            end
            ST_RAD: begin
                case (r_k)
                    4'd0: begin
                        iss_go = 1'b1;  iss_clr = 1'b1;
                        iss_a = AW'(r_dd);  iss_b = BW'(r_dd);
                    end
                    4'd1: begin
                        iss_go = 1'b1;  iss_sub = 1'b1;
                        iss_a = AW'($signed({1'b0, r_r}));
                        iss_b = BW'($signed({1'b0, r_r}));
                    end
                    default: begin
                        n_nr2  = r_acc[NR2_W-1:0];
                        n_i    = '0;
                        n_k    = '0;
                        n_spos = 1'b0;
                        n_sneg = 1'b0;
                        n_st   = (r_cnt >= CW'(3)) ? ST_INSIDE : ST_EDGE;
                    end
                endcase
            end
            ST_INSIDE: begin
                case (r_k)
                    4'd0: begin
                        n_st = ST_RDA;  n_ret = ST_INSIDE;  n_k = 4'd1;
                    end
                    4'd1: begin
                        iss_go = 1'b1;  iss_clr = 1'b1;
                        iss_a = AW'(r_n[2]);  iss_b = w_bv[1];
                    end
                    4'd2: begin
                        iss_go = 1'b1;  iss_sub = 1'b1;
                        iss_a = AW'(r_n[1]);  iss_b = w_bv[2];
                    end
                    4'd3: begin
                        n_m[0] = r_acc[MW-1:0];
                        iss_go = 1'b1;  iss_clr = 1'b1;
                        iss_a = AW'(r_n[0]);  iss_b = w_bv[2];
                    end
                    4'd4: begin
                        iss_go = 1'b1;  iss_sub = 1'b1;
                        iss_a = AW'(r_n[2]);  iss_b = w_bv[0];
                    end
                    4'd5: begin
                        n_m[1] = r_acc[MW-1:0];
                        iss_go = 1'b1;  iss_clr = 1'b1;
                        iss_a = AW'(r_n[1]);  iss_b = w_bv[0];
                    end
                    4'd6: begin
                        iss_go = 1'b1;  iss_sub = 1'b1;
                        iss_a = AW'(r_n[0]);  iss_b = w_bv[1];
                    end
                    4'd7: begin
                        n_m[2] = r_acc[MW-1:0];
                        iss_go = 1'b1;  iss_clr = 1'b1;
                        iss_a = AW'(r_m[0]);  iss_b = w_av[0];
                    end
                    4'd8: begin
                        iss_go = 1'b1;  iss_a = AW'(r_m[1]);  iss_b = w_av[1];
                    end
                    4'd9: begin
                        iss_go = 1'b1;  iss_a = AW'(r_m[2]);  iss_b = w_av[2];
                    end
                    default: begin
                        n_spos = r_spos || (!r_acc[AW-1] && (r_acc != '0));
                        n_sneg = r_sneg || r_acc[AW-1];
                        n_k    = '0;
                        if (w_last) begin
                            n_i = '0;
                            if (!(n_spos && n_sneg)) begin
                                n_touch = 1'b1;
                                n_st    = ST_OUT;
                            end else begin
                                n_st = ST_EDGE;
                            end
                        end else begin
                            n_i = r_i + 1'b1;
                        end
                    end
                endcase
            end
            ST_EDGE: begin
                case (r_k)
                    4'd0: begin
                        n_st = ST_RDA;  n_ret = ST_EDGE;  n_k = 4'd1;
                    end
                    4'd1: begin
                        iss_go = 1'b1;  iss_clr = 1'b1;
                        iss_a = AW'(w_ac[0]);  iss_b = w_ab[0];
                    end
                    4'd2: begin
                        iss_go = 1'b1;  iss_a = AW'(w_ac[1]);  iss_b = w_ab[1];
                    end
                    4'd3: begin
                        iss_go = 1'b1;  iss_a = AW'(w_ac[2]);  iss_b = w_ab[2];
                    end
                    4'd4: begin
                        n_d = r_acc[MW-1:0];
                        if (r_acc[AW-1]) begin
                            n_q  = w_ac;
                            n_st = ST_CLOSE;
                            n_k  = '0;
                        end else begin
                            iss_go = 1'b1;  iss_clr = 1'b1;
                            iss_a = AW'(w_ab[0]);  iss_b = w_ab[0];
                        end
                    end
                    4'd5: begin
                        iss_go = 1'b1;  iss_a = AW'(w_ab[1]);  iss_b = w_ab[1];
                    end
                    4'd6: begin
                        iss_go = 1'b1;  iss_a = AW'(w_ab[2]);  iss_b = w_ab[2];
                    end
                    4'd7: begin
                        if ($signed(r_acc[MW-1:0]) <= r_d) begin
                            n_q  = w_pb;
                            n_st = ST_CLOSE;
                            n_k  = '0;
                        end else begin
                            n_acc = AW'(r_d);
                            n_ma  = r_acc;
                            n_t   = '0;
                            n_bit = '0;
                            n_ret = ST_EDGE;
                            n_k   = 4'd8;
                            n_st  = ST_DIV;
                        end
                    end
                    4'd8: begin
                        iss_go = 1'b1;  iss_clr = 1'b1;
                        iss_a = AW'(w_ab[0]);  iss_b = w_tb;
                    end
                    4'd9: begin
                        n_q[0] = w_ac[0] - w_tq;
                        iss_go = 1'b1;  iss_clr = 1'b1;
                        iss_a = AW'(w_ab[1]);  iss_b = w_tb;
                    end
                    4'd10: begin
                        n_q[1] = w_ac[1] - w_tq;
                        iss_go = 1'b1;  iss_clr = 1'b1;
                        iss_a = AW'(w_ab[2]);  iss_b = w_tb;
                    end
                    default: begin
                        n_q[2] = w_ac[2] - w_tq;
                        n_st   = ST_CLOSE;
                        n_k    = '0;
                    end
                endcase
            end
            ST_CLOSE: begin
                case (r_k)
                    4'd0: begin
                        iss_go = 1'b1;  iss_nr2 = 1'b1;
                        iss_a = AW'(r_q[0]);  iss_b = r_q[0];
                    end
                    4'd1: begin
                        iss_go = 1'b1;  iss_a = AW'(r_q[1]);  iss_b = r_q[1];
                    end
                    4'd2: begin
                        iss_go = 1'b1;  iss_a = AW'(r_q[2]);  iss_b = r_q[2];
                    end
                    default: begin
                        n_k = '0;
                        if (r_acc[AW-1] || (r_acc == '0)) begin
                            n_touch = 1'b1;
                            n_st    = ST_OUT;
                        end else if (w_last) begin
                            n_touch = 1'b0;
                            n_st    = ST_OUT;
                        end else begin
                            n_i  = r_i + 1'b1;
                            n_st = ST_EDGE;
                        end
                    end
                endcase
            end
            ST_MUL: begin
                n_acc = w_sum;
                n_ma  = r_ma <<< 1;
                n_mb  = r_mb >>> 1;
                n_bit = r_bit + 1'b1;
                if (r_bit == BCW'(BW - 1)) begin
                    n_st = r_ret;
                end
            end
            ST_DIV: begin
                n_acc = w_sum[AW-1] ? w_alu_x : w_sum;
                n_t   = {r_t[T_W-2:0], ~w_sum[AW-1]};
                n_bit = r_bit + 1'b1;
                if (r_bit == BCW'(T_W - 1)) begin
                    n_st = r_ret;
                end
            end
            ST_RDA: begin
                n_st = ST_RDB;
            end
            ST_RDB: begin
                n_va = w_rdv;
                n_st = ST_RDC;
            end
            ST_RDC: begin
                n_vb = w_rdv;
                n_st = r_ret;
            end
            ST_OUT: begin
                n_cnt = '0;
                n_st  = ST_IDLE;
            end
            default: begin
                n_st = ST_IDLE;
            end
        endcase

        if (iss_go) begin
            n_ma   = iss_a;
            n_mb   = iss_b;
            n_msub = iss_sub;
            n_acc  = iss_nr2 ? AW'(r_nr2) : (iss_clr ? '0 : r_acc);
            n_bit  = '0;
            n_ret  = r_st;
            n_k    = r_k + 1'b1;
            n_st   = ST_MUL;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st  <= ST_IDLE;
            r_ret <= ST_IDLE;
            r_k   <= '0;
            r_i   <= '0;
            r_cnt <= '0;
            r_bit <= '0;
        end else begin
            r_st  <= n_st;
            r_ret <= n_ret;
            r_k   <= n_k;
            r_i   <= n_i;
            r_cnt <= n_cnt;
            r_bit <= n_bit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_c    <= n_c;
        r_n    <= n_n;
        r_r    <= n_r;
        r_dd   <= n_dd;
        r_p    <= n_p;
        r_nr2  <= n_nr2;
        r_m    <= n_m;
        r_d    <= n_d;
        r_t    <= n_t;
        r_va   <= n_va;
        r_vb   <= n_vb;
        r_q    <= n_q;
        r_acc  <= n_acc;
        r_ma   <= n_ma;
        r_mb   <= n_mb;
        r_msub <= n_msub;
        r_spos <= n_spos;
        r_sneg <= n_sneg;
        r_touch <= n_touch;
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_corner[r_cnt[IW-1:0]] <= {i_vert_x, i_vert_y, i_vert_z};
        end
        r_rd <= r_corner[w_raddr];
    end

    a_final_goes_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_final_vertex) |=> busy)
        else $error("final beat did not start evaluation");

    a_plain_beat_stays_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && !i_final_vertex) |=> !busy)
        else $error("non-final beat left the core busy");

    a_result_then_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> (!busy && !o_valid && r_cnt == '0))
        else $error("core did not return to idle after result");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(MAX_CORNERS))
        else $error("corner count overflow");

    a_mul_bit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == ST_MUL) |-> (r_bit <= BCW'(BW - 1)))
        else $error("multiplier step counter out of range");

endmodule

`default_nettype wire
